[sv/tbrp_pkg.sv]
package tbrp_pkg;

    localparam int IDX_W     = 4;
    localparam int RATE_W    = 20;
    localparam int LEVEL_W   = 36;
    localparam int NOW_W     = 48;
    localparam int ELAPSED_W = 16;
    localparam int TOKENS_W  = 20;

    // item kinds
    localparam logic KIND_SETUP   = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // one token is 60000 units; a rate of R per minute adds R units per ms
    localparam logic [LEVEL_W-1:0]   UNITS_PER_TOKEN = LEVEL_W'(60000);
    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_MS  = ELAPSED_W'(60000);

    // level / 60000 == (level >> 5) / 1875, done by reciprocal multiply
    localparam int DIV_SHIFT   = 5;
    localparam int DIV_X_W     = LEVEL_W - DIV_SHIFT;
    localparam int RECIP_SHIFT = 42;
    localparam int RECIP_W     = 32;
    localparam int PROD_W      = DIV_X_W + RECIP_W;
    localparam int QEST_W      = PROD_W - RECIP_SHIFT;
    localparam int QM_W        = 32;
    localparam logic [QM_W-1:0] DIV_BASE = QM_W'(1875);
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd1875);

endpackage

[sv/tbrp_req_if.sv]
interface tbrp_req_if import tbrp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                kind;
    logic [IDX_W-1:0]    provider_index;
    logic [RATE_W-1:0]   rate_per_minute;
    logic [NOW_W-1:0]    now_ms;

    modport source (output valid, kind, provider_index, rate_per_minute, now_ms,
                    input ready);
    modport sink   (input valid, kind, provider_index, rate_per_minute, now_ms,
                    output ready);
endinterface

[sv/tbrp_res_if.sv]
interface tbrp_res_if import tbrp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [TOKENS_W-1:0] tokens_left;

    modport source (output valid, granted, tokens_left, input ready);
    modport sink   (input valid, granted, tokens_left, output ready);
endinterface

[sv/tbrp_bucket_mem.sv]
module tbrp_bucket_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 104
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/tbrp_divider.sv]
module tbrp_divider import tbrp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [LEVEL_W-1:0]  i_level,
    output logic                o_valid,
    output logic [TOKENS_W-1:0] o_tokens
);

    logic [2:0]             r_valid;
    logic [DIV_X_W-1:0]     r_x1;
    logic [DIV_X_W-1:0]     r_x2;
    logic [PROD_W-1:0]      r_prod;
    logic [QEST_W-1:0]      r_qest;
    logic [QM_W-1:0]        r_qm;
    logic [TOKENS_W-1:0]    r_tokens;
    logic [DIV_X_W-1:0]     x_in;
    logic [QEST_W-1:0]      qest;
    logic [QM_W-1:0]        rem;
    logic [QEST_W-1:0]      qfix;

    assign x_in = i_level[LEVEL_W-1:DIV_SHIFT];
    assign qest = r_prod[PROD_W-1:RECIP_SHIFT];
    assign rem  = QM_W'(r_x2) - r_qm;
    // estimate is low by at most one
    assign qfix = (rem >= DIV_BASE) ? r_qest + QEST_W'(1) : r_qest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x1     <= x_in;
        r_prod   <= PROD_W'(x_in) * PROD_W'(RECIP);
        r_x2     <= r_x1;
        r_qest   <= qest;
        r_qm     <= QM_W'(qest) * DIV_BASE;
        r_tokens <= TOKENS_W'(qfix);
    end

    assign o_valid  = r_valid[2];
    assign o_tokens = r_tokens;

endmodule

[sv/token_bucket_rate_policer.sv]
// Per-client token bucket policer.
// i_req carries set-up items (kind 0: load a client's per-minute limit and
// fill its bucket) and requests (kind 1: refill by elapsed time, then grant
// and take one token if one is left). o_res returns one beat per request:
// granted and whole tokens left; set-up items return nothing.
// Bucket rate, level and last refill time live in one synchronous memory of
// NUM_CLIENTS words; per-client active bits sit in flops.
// One item is in work at a time; i_req.ready is high only while idle.
// A limited request runs through these steps in order: memory read,
// elapsed and cap, refill multiply, add and clamp, take and write back,
// a three-stage reciprocal divide by 60000, then the output register.
// A request to an unconfigured or unlimited client goes from the read
// straight to the output register; a set-up item runs read, multiply,
// write, or only the read when its index lies beyond the table.
// Reset clears all active bits; the memory needs no clearing pass.
// While o_res is stalled with a result held, the next item is still taken;
// its result waits in the final step until the output register frees.
module token_bucket_rate_policer import tbrp_pkg::*; #(
    parameter int NUM_CLIENTS = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbrp_req_if.sink    i_req,
    tbrp_res_if.source  o_res
);

    localparam int AW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int DW = RATE_W + LEVEL_W + TIME_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_SUM,
        S_TAKE,
        S_DIV,
        S_RESP
    } t_state;

    t_state                 r_state;
    logic                   r_kind;
    logic                   r_oob;
    logic [AW-1:0]          r_addr;
    logic [RATE_W-1:0]      r_rate;
    logic [TIME_BITS-1:0]   r_now;
    logic [LEVEL_W-1:0]     r_cap;
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [LEVEL_W-1:0]     r_add;
    logic [LEVEL_W-1:0]     r_level;
    logic                   r_granted;
    logic [TOKENS_W-1:0]    r_tokens;
    logic                   r_out_valid;
    logic                   r_out_granted;
    logic [TOKENS_W-1:0]    r_out_tokens;
    logic                   r_active [NUM_CLIENTS];

    logic                   req_fire;
    logic                   out_free;
    logic [DW-1:0]          rd_data;
    logic [RATE_W-1:0]      rd_rate;
    logic [LEVEL_W-1:0]     rd_level;
    logic [TIME_BITS-1:0]   rd_time;
    logic [TIME_BITS-1:0]   diff;
    logic [RATE_W-1:0]      rate_sel;
    logic                   unlimited;
    logic [LEVEL_W:0]       sum;
    logic                   take_ok;
    logic [LEVEL_W-1:0]     new_level;
    logic                   wr_en;
    logic [DW-1:0]          wr_data;
    logic                   div_start;
    logic                   div_valid;
    logic [TOKENS_W-1:0]    div_tokens;

    assign req_fire = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_res.ready;

    assign rd_rate  = rd_data[DW-1 -: RATE_W];
    assign rd_level = rd_data[TIME_BITS +: LEVEL_W];
    assign rd_time  = rd_data[TIME_BITS-1:0];

    // elapsed time wraps modulo 2^TIME_BITS
    assign diff      = r_now - rd_time;
    assign rate_sel  = (r_kind == KIND_REQUEST) ? rd_rate : r_rate;
    assign unlimited = r_oob || !r_active[r_addr] || (rd_rate == '0);

    assign sum       = (LEVEL_W+1)'(rd_level) + (LEVEL_W+1)'(r_add);
    assign take_ok   = (r_level >= UNITS_PER_TOKEN);
    assign new_level = take_ok ? r_level - UNITS_PER_TOKEN : r_level;

    always_comb begin
        wr_en   = 1'b0;
        wr_data = {rd_rate, new_level, r_now};
        if (r_state == S_MUL && r_kind == KIND_SETUP) begin
            wr_en   = 1'b1;
            wr_data = {r_rate, r_cap, r_now};
        end else if (r_state == S_TAKE) begin
            wr_en   = 1'b1;
        end
    end

    assign div_start = (r_state == S_TAKE);

    tbrp_bucket_mem #(
        .DEPTH (NUM_CLIENTS),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (req_fire),
        .i_rd_addr (AW'(i_req.provider_index)),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data)
    );

    tbrp_divider u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_level  (new_level),
        .o_valid  (div_valid),
        .o_tokens (div_tokens)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_active[i] <= 1'b0;
            end
        end else if (r_state == S_MUL && r_kind == KIND_SETUP) begin
            r_active[r_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_kind  <= i_req.kind;
                        r_oob   <= ({28'd0, i_req.provider_index} >= 32'(NUM_CLIENTS));
                        r_addr  <= AW'(i_req.provider_index);
                        r_rate  <= i_req.rate_per_minute;
                        r_now   <= TIME_BITS'(i_req.now_ms);
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cap     <= LEVEL_W'(rate_sel) * UNITS_PER_TOKEN;
                    r_elapsed <= (diff > TIME_BITS'(MAX_ELAPSED_MS)) ?
                                 MAX_ELAPSED_MS : ELAPSED_W'(diff);
                    if (r_kind == KIND_SETUP) begin
                        // drop set-up beats for clients beyond the table
                        r_state <= r_oob ? S_IDLE : S_MUL;
                    end else if (unlimited) begin
                        r_granted <= 1'b1;
                        r_tokens  <= '0;
                        r_state   <= S_RESP;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_add   <= LEVEL_W'(r_elapsed) * LEVEL_W'(rd_rate);
                    r_state <= (r_kind == KIND_SETUP) ? S_IDLE : S_SUM;
                end
                S_SUM: begin
                    r_level <= (sum > (LEVEL_W+1)'(r_cap)) ? r_cap : LEVEL_W'(sum);
                    r_state <= S_TAKE;
                end
                S_TAKE: begin
                    r_granted <= take_ok;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    if (div_valid) begin
                        r_tokens <= div_tokens;
                        r_state  <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= r_granted;
                        r_out_tokens  <= r_tokens;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.granted     = r_out_granted;
    assign o_res.tokens_left = r_out_tokens;

`ifndef SYNTHESIS
    a_denied_no_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.granted |-> o_res.tokens_left == '0)
        else $error("denied result carries tokens");

    a_level_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TAKE |-> r_level <= r_cap)
        else $error("refilled level above cap");

    a_div_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_valid |-> r_state == S_DIV)
        else $error("divider result outside wait step");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_fire |=> r_state == S_READ)
        else $error("accepted beat did not start a read");
`endif

endmodule

[dv/tb_token_bucket_rate_policer.sv]
module tb_token_bucket_rate_policer;
    import tbrp_pkg::*;

    localparam int N_CLIENTS    = 16;
    localparam int MAX_WAIT     = 18;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  idx;
        logic [RATE_W-1:0] rate;
        logic [NOW_W-1:0]  now;
    } t_beat;

    typedef struct packed {
        logic                granted;
        logic [TOKENS_W-1:0] tokens;
    } t_grant;

    typedef struct {
        t_beat  beat;
        bit     typed;
        t_grant res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tbrp_req_if req_bus ();
    tbrp_res_if res_bus ();

    token_bucket_rate_policer #(
        .NUM_CLIENTS (N_CLIENTS),
        .TIME_BITS   (NOW_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_res   (res_bus)
    );

    // predictor copy of the per-client buckets
    bit                 bucket_on   [N_CLIENTS];
    logic [RATE_W-1:0]  bucket_rpm  [N_CLIENTS];
    logic [LEVEL_W-1:0] bucket_fill [N_CLIENTS];
    logic [NOW_W-1:0]   bucket_stamp[N_CLIENTS];

    t_grant pending_grants[$];
    t_row   rows[$];
    int     errors = 0;
    int     cycles = 0;
    bit     hold_off = 1'b0;
    bit     sender_burst = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s at cycle %0d: got %0d, want %0d", what, cycles, got, want);
        errors++;
    endtask

    // returns 1 when the beat produces a result
    function automatic bit police_request(input t_beat b, output t_grant res);
        logic [63:0]      cap;
        logic [63:0]      lvl;
        logic [63:0]      gap_ms;
        logic [NOW_W-1:0] span;
        int               c;
        c = int'(b.idx);
        res = '0;
        if (b.kind == KIND_SETUP) begin
            bucket_on[c]    = 1'b1;
            bucket_rpm[c]   = b.rate;
            bucket_fill[c]  = LEVEL_W'(64'(b.rate) * 64'(UNITS_PER_TOKEN));
            bucket_stamp[c] = b.now;
            return 1'b0;
        end
        if (!bucket_on[c] || bucket_rpm[c] == '0) begin
            res.granted = 1'b1;
            res.tokens  = '0;
            return 1'b1;
        end
        cap    = 64'(bucket_rpm[c]) * 64'(UNITS_PER_TOKEN);
        span   = b.now - bucket_stamp[c];
        // clamp long idle and backward steps to one full refill
        gap_ms = (span > NOW_W'(MAX_ELAPSED_MS)) ? 64'(MAX_ELAPSED_MS) : 64'(span);
        lvl    = 64'(bucket_fill[c]) + gap_ms * 64'(bucket_rpm[c]);
        if (lvl > cap)
            lvl = cap;
        bucket_stamp[c] = b.now;
        if (lvl >= 64'(UNITS_PER_TOKEN)) begin
            lvl = lvl - 64'(UNITS_PER_TOKEN);
            res.granted = 1'b1;
        end else begin
            res.granted = 1'b0;
        end
        bucket_fill[c] = LEVEL_W'(lvl);
        res.tokens     = TOKENS_W'(lvl / 64'(UNITS_PER_TOKEN));
        return 1'b1;
    endfunction

    task automatic add_row(input logic kind, input int idx, input logic [RATE_W-1:0] rate,
                           input logic [NOW_W-1:0] now, input bit typed,
                           input logic granted, input int tokens);
        t_row r;
        r.beat.kind    = kind;
        r.beat.idx     = IDX_W'(idx);
        r.beat.rate    = rate;
        r.beat.now     = now;
        r.typed        = typed;
        r.res.granted  = granted;
        r.res.tokens   = TOKENS_W'(tokens);
        rows.insert(rows.size(), r);
    endtask

    task automatic send_beat(input t_beat b, input bit typed, input t_grant typed_res);
        int     gap;
        t_grant res;
        bit     has_res;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) begin
                // scramble the idle payload
                req_bus.kind            = 1'($urandom);
                req_bus.provider_index  = IDX_W'($urandom);
                req_bus.rate_per_minute = RATE_W'($urandom);
                req_bus.now_ms          = NOW_W'({$urandom, $urandom});
                @(negedge i_clk);
            end
        end
        req_bus.kind            = b.kind;
        req_bus.provider_index  = b.idx;
        req_bus.rate_per_minute = b.rate;
        req_bus.now_ms          = b.now;
        req_bus.valid           = 1'b1;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        has_res = police_request(b, res);
        if (has_res)
            pending_grants.insert(pending_grants.size(), typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_grants.size() == 0) begin
                flag_mismatch("unexpected result", res_bus.tokens_left, 0);
            end else begin
                want = pending_grants[0];
                pending_grants.delete(0);
                if (res_bus.granted !== want.granted)
                    flag_mismatch("granted", res_bus.granted, want.granted);
                if (res_bus.tokens_left !== want.tokens)
                    flag_mismatch("tokens_left", res_bus.tokens_left, want.tokens);
            end
        end
    end

    // result side: random stalls, zero-stall stretches, one long hold
    initial begin
        int stall;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        res_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off && !held) begin
                held = 1'b1;
                stall = LONG_HOLD;
            end else if ((taken / 50) % 4 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, MAX_WAIT);
            end
            if (stall > 0) begin
                res_bus.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (res_bus.valid !== 1'b1);
            taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        t_beat            b;
        t_grant           none;
        logic [NOW_W-1:0] clock_ms;
        int               pick;

        i_rst_n                 = 1'b0;
        req_bus.valid           = 1'b0;
        req_bus.kind            = KIND_SETUP;
        req_bus.provider_index  = '0;
        req_bus.rate_per_minute = '0;
        req_bus.now_ms          = '0;
        none                    = '0;
        for (int i = 0; i < N_CLIENTS; i++) begin
            bucket_on[i]    = 1'b0;
            bucket_rpm[i]   = '0;
            bucket_fill[i]  = '0;
            bucket_stamp[i] = '0;
        end

        // unconfigured clients after reset
        add_row(KIND_REQUEST, 0, 20'hFFFFF, 48'h0, 1, 1'b1, 0);
        add_row(KIND_REQUEST, 15, 20'h0, 48'hFFFF_FFFF_FFFF, 1, 1'b1, 0);
        // zero limit means unlimited
        add_row(KIND_SETUP, 1, 20'd0, 48'd100, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 1, 20'd0, 48'd200, 1, 1'b1, 0);
        // one token: take it, then get denied, then refill
        add_row(KIND_SETUP, 2, 20'd1, 48'd1000, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 2, 20'd0, 48'd1000, 1, 1'b1, 0);
        add_row(KIND_REQUEST, 2, 20'd0, 48'd1000, 1, 1'b0, 0);
        add_row(KIND_REQUEST, 2, 20'd0, 48'd31000, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 2, 20'd0, 48'd200000, 1, 1'b1, 0);
        // backward time counts as a full refill
        add_row(KIND_REQUEST, 2, 20'd0, 48'd100, 1, 1'b1, 0);
        // top rate across the timer wrap
        add_row(KIND_SETUP, 3, 20'd1000000, 48'hFFFF_FFFF_FF00, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 3, 20'd0, 48'hFFFF_FFFF_FF00, 1, 1'b1, 999999);
        add_row(KIND_REQUEST, 3, 20'd0, 48'h10, 0, 1'b0, 0);
        // largest rate that the rate field holds
        add_row(KIND_SETUP, 4, 20'hFFFFF, 48'h5555_5555_5555, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 4, 20'hAAAAA, 48'h5555_5555_5555, 1, 1'b1, 1048574);
        add_row(KIND_SETUP, 5, 20'd60, 48'hAAAA_AAAA_AAAA, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 5, 20'h55555, 48'hAAAA_AAAA_AAAA, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 5, 20'd0, 48'hAAAA_AAAA_ACA0, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 5, 20'd0, 48'hAAAA_AAAA_AE00, 0, 1'b0, 0);
        // reload a limited client as unlimited
        add_row(KIND_SETUP, 2, 20'd0, 48'd0, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 2, 20'd0, 48'd5, 1, 1'b1, 0);
        // drain a two-token bucket with no time passing between requests
        add_row(KIND_SETUP, 6, 20'd2, 48'd0, 0, 1'b0, 0);
        add_row(KIND_REQUEST, 6, 20'd0, 48'd0, 1, 1'b1, 1);
        add_row(KIND_REQUEST, 6, 20'd0, 48'd0, 1, 1'b1, 0);
        add_row(KIND_REQUEST, 6, 20'd0, 48'd0, 1, 1'b0, 0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].typed, rows[i].res);

        clock_ms = 48'd300000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sender_burst = ((n / 64) % 4 == 3);
            if (n == 200)
                hold_off = 1'b1;
            if (n == 400) begin
                // pause until the result side is empty
                req_bus.valid = 1'b0;
                while (pending_grants.size() != 0) @(negedge i_clk);
            end

            pick = $urandom_range(0, 99);
            if (pick < 70)
                clock_ms = clock_ms + NOW_W'($urandom_range(0, 300));
            else if (pick < 85)
                clock_ms = clock_ms + NOW_W'($urandom_range(0, 3000));
            else if (pick < 92)
                clock_ms = clock_ms + NOW_W'($urandom_range(0, 120000));
            else if (pick < 96)
                clock_ms = clock_ms - NOW_W'($urandom_range(0, 5000));
            else if (pick < 98)
                clock_ms = NOW_W'({$urandom, $urandom});
            else
                clock_ms = {NOW_W{1'b1}} - NOW_W'($urandom_range(0, 400));

            b.now  = clock_ms;
            b.kind = ($urandom_range(0, 99) < 15) ? KIND_SETUP : KIND_REQUEST;
            b.idx  = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 3)) : IDX_W'($urandom);
            if (b.kind == KIND_SETUP) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    b.rate = '0;
                else if (pick == 1)
                    b.rate = RATE_W'($urandom);
                else if (pick == 2)
                    b.rate = RATE_W'(1000000);
                else
                    b.rate = RATE_W'($urandom_range(1, 8));
            end else begin
                b.rate = RATE_W'($urandom);
            end
            send_beat(b, 1'b0, none);
        end
        req_bus.valid = 1'b0;

        while (pending_grants.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending_grants.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
sv/tbrp_pkg.sv
sv/tbrp_req_if.sv
sv/tbrp_res_if.sv
sv/tbrp_bucket_mem.sv
sv/tbrp_divider.sv
sv/token_bucket_rate_policer.sv
dv/tb_token_bucket_rate_policer.sv
